// ----- sv/dtp_pkg.sv -----
package dtp_pkg;

  localparam int unsigned StoreDepth = 14;
  localparam int unsigned CountW     = 4;

  localparam logic [7:0]  CharTerm = 8'h00;
  localparam logic [7:0]  CharZero = 8'h30;
  localparam logic [7:0]  CharNine = 8'h39;

  localparam logic [13:0] YearMin  = 14'd1900;
  localparam logic [13:0] YearMax  = 14'd2099;
  localparam logic [11:0] YearCent = 12'd2000;

  // multiply-shift reciprocal of 7 for sums below 4096
  localparam logic [13:0] RecipSeven = 14'd9363;

  // fields decoded from the kept digits, before range checks
  typedef struct packed {
    logic        enough;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hours;
    logic [6:0]  minutes;
    logic [6:0]  seconds;
  } fields_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } result_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap_yr);
    logic [4:0] d;
    unique case (m) inside
      4'd2:                     d = leap_yr ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

  // per-month offset of the weekday sum (January first)
  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] t;
    unique case (m) inside
      4'd2, 4'd6:               t = 3'd3;
      4'd3, 4'd11:              t = 3'd2;
      4'd4:                     t = 3'd5;
      4'd7:                     t = 3'd5;
      4'd8:                     t = 3'd1;
      4'd9, 4'd12:              t = 3'd4;
      4'd10:                    t = 3'd6;
      default:                  t = 3'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/dtp_collect.sv -----
module dtp_collect (
  input  logic               clk,
  input  logic               rst,
  input  logic               xfer,
  input  logic [7:0]         char_code,
  output dtp_pkg::fields_t   fields
);
  import dtp_pkg::*;

  logic [3:0]        digit_store [StoreDepth];
  logic [CountW-1:0] digit_count;
  logic              is_digit;
  logic              is_term;
  logic [7:0]        digit_byte;

  assign is_term    = (char_code == CharTerm);
  assign is_digit   = (char_code >= CharZero) && (char_code <= CharNine);
  assign digit_byte = char_code - CharZero;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (xfer) begin
      if (is_term) begin
        digit_count <= '0;
      end else if (is_digit && (digit_count < CountW'(StoreDepth))) begin
        digit_count <= digit_count + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && !is_term && is_digit && (digit_count < CountW'(StoreDepth))) begin
      digit_store[digit_count] <= digit_byte[3:0];
    end
  end

  function automatic logic [6:0] pair_at(input int unsigned pos, input logic [6:0] dflt,
                                         input logic [CountW-1:0] cnt,
                                         input logic [3:0] hi, input logic [3:0] lo);
    logic [6:0] v;
    if (cnt < CountW'(pos + 2)) begin
      v = dflt;
    end else begin
      v = 7'(hi) * 7'd10 + 7'(lo);
    end
    return v;
  endfunction

  logic [6:0] cent_pair;
  logic [6:0] yr_pair;

  always_comb begin
    cent_pair      = pair_at(0, 7'd0, digit_count, digit_store[0], digit_store[1]);
    yr_pair        = pair_at(2, 7'd0, digit_count, digit_store[2], digit_store[3]);
    fields.enough  = (digit_count >= CountW'(4));
    fields.year    = 14'(cent_pair) * 14'd100 + 14'(yr_pair);
    fields.month   = pair_at(4,  7'd1, digit_count, digit_store[4],  digit_store[5]);
    fields.day     = pair_at(6,  7'd1, digit_count, digit_store[6],  digit_store[7]);
    fields.hours   = pair_at(8,  7'd0, digit_count, digit_store[8],  digit_store[9]);
    fields.minutes = pair_at(10, 7'd0, digit_count, digit_store[10], digit_store[11]);
    fields.seconds = pair_at(12, 7'd0, digit_count, digit_store[12], digit_store[13]);
  end

endmodule

// ----- sv/dtp_check.sv -----
module dtp_check (
  input  dtp_pkg::fields_t  fields,
  output dtp_pkg::result_t  result
);
  import dtp_pkg::*;

  logic        date_ok;
  logic        ok;
  logic        leap_yr;
  logic [3:0]  mon;
  logic [11:0] yr;
  logic [11:0] yy;
  logic [4:0]  cent;
  logic [2:0]  quad_cent;
  logic [11:0] sum;
  logic [25:0] prod;
  logic [9:0]  quot;
  logic [11:0] rem;

  always_comb begin
    mon     = fields.month[3:0];
    yr      = fields.year[11:0];
    date_ok = fields.enough && (fields.year >= YearMin) && (fields.year <= YearMax) &&
              (fields.month >= 7'd1) && (fields.month <= 7'd12);
    // within 1900..2099 only 2000 is a century leap year
    leap_yr = (yr[1:0] == 2'b00) && (yr != YearMin[11:0]);
    ok      = date_ok && (fields.day >= 7'd1) &&
              (fields.day <= 7'(month_days(mon, leap_yr))) &&
              (fields.hours <= 7'd23) && (fields.minutes <= 7'd59) &&
              (fields.seconds <= 7'd59);

    // January and February count with the previous year
    yy        = (mon <= 4'd2) ? yr - 12'd1 : yr;
    cent      = (yy >= YearCent) ? 5'd20 : ((yy >= YearMin[11:0]) ? 5'd19 : 5'd18);
    quad_cent = (yy >= YearCent) ? 3'd5 : 3'd4;
    sum       = yy + (yy >> 2) + 12'(quad_cent) + 12'(month_offset(mon)) +
                12'(fields.day[4:0]) - 12'(cent);

    prod = 26'(sum) * 26'(RecipSeven);
    quot = prod[25:16];
    rem  = sum - 12'(quot) * 12'd7;

    result = '0;
    if (ok) begin
      result.valid_res = 1'b1;
      result.year      = yr;
      result.month     = mon;
      result.day       = fields.day[4:0];
      result.weekday   = rem[2:0];
      result.hours     = fields.hours[4:0];
      result.minutes   = fields.minutes[5:0];
      result.seconds   = fields.seconds[5:0];
    end
  end

endmodule

// ----- sv/datetime_digit_parser_weekday_core.sv -----
// Compact date-time parser: takes one character byte per transfer on the char
// channel, keeps up to fourteen decimal digits (YYYYMMDDhhmmss), ignores every
// other byte, and on a zero byte emits one result on the res channel with the
// checked date, time and weekday (0 Sunday). A result whose valid_res is low
// has every field zero. The block takes a character every cycle while the
// result side keeps up; the fields of a terminated string are held in the
// decode register, then checked and given their weekday combinationally as
// they load into the output register. Characters keep flowing while one
// result waits; the char channel stalls only while a second terminated string
// sits in the decode register behind a result that has not yet transferred.
module datetime_digit_parser_weekday_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_code,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        valid_res,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [2:0]  weekday,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds
);
  import dtp_pkg::*;

  logic     char_xfer;
  logic     term_xfer;
  logic     out_free;
  logic     dec_adv;
  logic     dec_valid;
  fields_t  dec_fields_next;
  fields_t  dec_fields;
  result_t  res_next;
  result_t  res;

  // Output register frees when empty or being drained this cycle
  assign out_free   = !res_valid || res_ready;
  assign dec_adv    = dec_valid && out_free;
  // Decode stage takes a new terminator when empty or moving on
  assign char_ready = !dec_valid || out_free;
  assign char_xfer  = char_valid && char_ready;
  assign term_xfer  = char_xfer && (char_code == CharTerm);

  // Digit store and pair decode
  dtp_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .xfer      (char_xfer),
    .char_code (char_code),
    .fields    (dec_fields_next)
  );

  // Hold the decoded fields of the string just terminated
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (term_xfer) begin
      dec_valid <= 1'b1;
    end else if (dec_adv) begin
      dec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_xfer) begin
      dec_fields <= dec_fields_next;
    end
  end

  // Range checks and weekday
  dtp_check u_check (
    .fields (dec_fields),
    .result (res_next)
  );

  // Result register: load on advance, drop on transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (dec_adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_adv) begin
      res <= res_next;
    end
  end

  assign valid_res = res.valid_res;
  assign year      = res.year;
  assign month     = res.month;
  assign day       = res.day;
  assign weekday   = res.weekday;
  assign hours     = res.hours;
  assign minutes   = res.minutes;
  assign seconds   = res.seconds;

  // Rejected results carry all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> year == 12'd0 && month == 4'd0 && day == 5'd0 &&
      weekday == 3'd0 && hours == 5'd0 && minutes == 6'd0 && seconds == 6'd0)
    else $error("invalid result with nonzero fields");

  // Accepted results stay within calendar ranges
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && valid_res |-> weekday <= 3'd6 && month >= 4'd1 && month <= 4'd12 &&
      day >= 5'd1 && hours <= 5'd23 && year >= 12'd1900 && year <= 12'd2099)
    else $error("valid result out of range");

  // A terminator always lands in the decode stage
  a_term_held: assert property (@(posedge clk) disable iff (rst)
    term_xfer |=> dec_valid)
    else $error("terminator lost");

  // A decoded string moves into an open output register
  a_dec_moves: assert property (@(posedge clk) disable iff (rst)
    dec_valid && out_free |=> res_valid)
    else $error("decode stage stalled with free output");

endmodule

// ----- test/dtp_result_checker.sv -----
`timescale 1ns / 1ps

module dtp_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_ready,
  input  logic [7:0]  char_code,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic        valid_res,
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [2:0]  weekday,
  input  logic [4:0]  hours,
  input  logic [5:0]  minutes,
  input  logic [5:0]  seconds,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          good_dates
);
  import dtp_pkg::*;

  // civil day count: days from 0000-03-01 shifted so that 1970-01-01 is zero
  localparam int EraDays    = 146097;
  localparam int EpochShift = 719468;
  localparam int Thursday   = 4;

  logic [3:0] kept_digits[StoreDepth];
  int         kept_n;
  result_t    dates_due[$];

  // value of the digit pair at pos, or dflt when the pair is incomplete
  function automatic int pair_or(input int pos, input int dflt);
    if (kept_n < pos + 2) return dflt;
    return kept_digits[pos] * 10 + kept_digits[pos + 1];
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    int  y, mo, d, h, mi, s, last_day;
    int  yy, era, yoe, mp, doe, days;
    bit  ok, leap_yr;
    if (rst) begin
      kept_n = 0;
      dates_due.delete();
      pending <= 0;
    end else begin
      if (char_valid && char_ready) begin
        if (char_code != CharTerm) begin
          if (char_code >= CharZero && char_code <= CharNine && kept_n < StoreDepth) begin
            kept_digits[kept_n] = 4'(char_code - CharZero);
            kept_n++;
          end
        end else begin
          want = '0;
          ok = (kept_n >= 4);
          if (ok) begin
            y  = pair_or(0, 0) * 100 + pair_or(2, 0);
            mo = pair_or(4, 1);
            d  = pair_or(6, 1);
            h  = pair_or(8, 0);
            mi = pair_or(10, 0);
            s  = pair_or(12, 0);
            ok = (y >= 1900) && (y <= 2099) && (mo >= 1) && (mo <= 12);
          end
          if (ok) begin
            leap_yr = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            case (mo) inside
              2:             last_day = leap_yr ? 29 : 28;
              4, 6, 9, 11:   last_day = 30;
              default:       last_day = 31;
            endcase
            ok = (d >= 1) && (d <= last_day) && (h <= 23) && (mi <= 59) && (s <= 59);
          end
          if (ok) begin
            // shift the year so it starts in March and leap days fall last
            yy   = (mo <= 2) ? y - 1 : y;
            era  = yy / 400;
            yoe  = yy - era * 400;
            mp   = (mo > 2) ? mo - 3 : mo + 9;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + (153 * mp + 2) / 5 + d - 1;
            days = era * EraDays + doe - EpochShift;
            want.valid_res = 1'b1;
            want.year      = 12'(y);
            want.month     = 4'(mo);
            want.day       = 5'(d);
            want.weekday   = 3'(((days % 7) + 7 + Thursday) % 7);
            want.hours     = 5'(h);
            want.minutes   = 6'(mi);
            want.seconds   = 6'(s);
          end
          dates_due.push_back(want);
          kept_n = 0;
        end
      end

      if (res_valid && res_ready) begin
        got = {valid_res, year, month, day, weekday, hours, minutes, seconds};
        if (dates_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no terminator pending: ok %0d %0d-%0d-%0d wd %0d",
                     $realtime, got.valid_res, got.year, got.month, got.day, got.weekday);
        end else begin
          want = dates_due.pop_front();
          checked++;
          if (want.valid_res) good_dates++;
          if (got.valid_res !== want.valid_res || got.year !== want.year ||
              got.month !== want.month || got.day !== want.day ||
              got.weekday !== want.weekday || got.hours !== want.hours ||
              got.minutes !== want.minutes || got.seconds !== want.seconds) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d differs", $realtime, checked);
              $display("  expected ok %0d %0d-%0d-%0d wd %0d %0d:%0d:%0d",
                       want.valid_res, want.year, want.month, want.day, want.weekday,
                       want.hours, want.minutes, want.seconds);
              $display("  actual   ok %0d %0d-%0d-%0d wd %0d %0d:%0d:%0d",
                       got.valid_res, got.year, got.month, got.day, got.weekday,
                       got.hours, got.minutes, got.seconds);
            end
          end
        end
      end
      pending <= dates_due.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import dtp_pkg::*;

  logic        clk;
  logic        rst        = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_ready;
  logic [7:0]  char_code  = 8'h00;
  logic        res_valid;
  logic        res_ready  = 1'b0;
  logic        valid_res;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;

  int mismatches, pending, checked, good_dates;

  // bytes of the string being built; the terminator is added on send
  logic [7:0]  text[$];
  int unsigned chars_sent   = 0;
  int unsigned strings_sent = 0;

  // when set, that side runs without idle cycles
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  datetime_digit_parser_weekday_core i_dut (.*);

  dtp_result_checker i_chk (.*);

  function automatic int unsigned idle_cycles(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Present one byte and hold it until the transfer. Keep valid high
  // across back-to-back bytes so it never drops and rises in one step.
  task automatic send_char(input logic [7:0] b);
    int unsigned gap;
    gap = idle_cycles(src_calm);
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= b;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    chars_sent++;
  endtask

  // Send the built string followed by its terminator, then clear it.
  task automatic send_text();
    foreach (text[i]) send_char(text[i]);
    send_char(CharTerm);
    text.delete();
    strings_sent++;
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 4))
      0:       return "-";
      1:       return ":";
      2:       return "T";
      3:       return " ";
      default: return "/";
    endcase
  endfunction

  // Build a YYYYMMDDhhmmss string, mostly in range, cut to a random
  // digit count, with separators, stray bytes and digits past the store.
  task automatic add_datetime();
    int y, mo, d, h, mi, s, n, extra, r;
    int dg[14];
    y  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9999) : $urandom_range(1900, 2099);
    mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    r  = $urandom_range(0, 7);
    d  = (r == 0) ? $urandom_range(0, 99) :
         (r < 3)  ? $urandom_range(28, 31) : $urandom_range(1, 28);
    h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    s  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    n  = $urandom_range(0, 1) ? 14 : $urandom_range(4, 14);
    if ($urandom_range(0, 15) == 0) n = $urandom_range(0, 3);
    dg[0]  = y / 1000;       dg[1]  = (y / 100) % 10;
    dg[2]  = (y / 10) % 10;  dg[3]  = y % 10;
    dg[4]  = mo / 10;        dg[5]  = mo % 10;
    dg[6]  = d / 10;         dg[7]  = d % 10;
    dg[8]  = h / 10;         dg[9]  = h % 10;
    dg[10] = mi / 10;        dg[11] = mi % 10;
    dg[12] = s / 10;         dg[13] = s % 10;
    for (int i = 0; i < n; i++) begin
      if (i >= 4 && i % 2 == 0 && $urandom_range(0, 2) == 0) text.push_back(pick_sep());
      if ($urandom_range(0, 29) == 0) text.push_back(8'($urandom_range(1, 255)));
      text.push_back(8'(CharZero + dg[i]));
    end
    // digits past the fourteenth must be dropped
    extra = (n == 14 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    repeat (extra) text.push_back(8'(CharZero + $urandom_range(0, 9)));
  endtask

  // Random bytes, half of them digits, any length up to past the store.
  task automatic add_noise();
    int len;
    len = $urandom_range(0, 20);
    repeat (len) begin
      if ($urandom_range(0, 1)) text.push_back(8'(CharZero + $urandom_range(0, 9)));
      else                      text.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Sink: draw a stall per result, then hold ready until one transfers.
  initial begin
    int unsigned gap;
    @(negedge rst);
    forever begin
      gap = idle_cycles(sink_calm);
      if (gap != 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still due", pending);
    $display("FAIL datetime_digit_parser_weekday_core");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty string, too few digits, year-only defaults,
    // full store with trailing digits, leap day, non-leap century,
    // odd digit count, month/day/hour/minute/second out of range,
    // years just outside the window, zero day, digit boundaries.
    send_text();
    add_str("123");                send_text();
    add_str("1900");               send_text();
    add_str("20991231235959771");  send_text();
    add_str("2024-02-29T12:30");   send_text();
    add_str("19000229");           send_text();
    add_str("2000022");            send_text();
    add_str("20231301");           send_text();
    add_str("20230431");           send_text();
    add_str("2023010124");         send_text();
    add_str("202301010060");       send_text();
    add_str("20230101000060");     send_text();
    add_str("18991231");           send_text();
    add_str("21000101");           send_text();
    add_str("20230100");           send_text();
    // bytes just around the digit range and with the top bits set
    text.push_back(8'h2F);
    text.push_back(8'h3A);
    text.push_back(8'hFF);
    text.push_back(8'h80);
    add_str("2024");
    send_text();

    // Random: mostly well-formed date strings, some pure noise. Flip the
    // idle modes now and then so both busy and gap-free stretches occur.
    while (chars_sent < 1600) begin
      if ($urandom_range(0, 5) == 0) src_calm  = ~src_calm;
      if ($urandom_range(0, 5) == 0) sink_calm = ~sink_calm;
      if ($urandom_range(0, 3) == 0) add_noise();
      else                           add_datetime();
      send_text();
    end
    char_valid <= 1'b0;

    // the count of due results is registered, so wait past the last transfer
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d characters in %0d strings; checked %0d results, %0d valid dates",
             chars_sent, strings_sent, checked, good_dates);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && pending == 0)
      $display("PASS datetime_digit_parser_weekday_core");
    else
      $display("FAIL datetime_digit_parser_weekday_core");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dtp_pkg.sv
sv/dtp_collect.sv
sv/dtp_check.sv
sv/datetime_digit_parser_weekday_core.sv
test/dtp_result_checker.sv
test/tb_top.sv
